// ===== hdl/fpn_pkg.sv =====
package fpn_pkg;

  // hash multipliers
  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  // quarter-wave sine coefficients, Q1.30
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598669;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  // register indexes
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_FREQ = 2'd1;
  localparam logic [1:0] REG_AMP  = 2'd2;

  localparam logic [15:0] FREQ_MIN  = 16'd6554;
  localparam logic [15:0] FREQ_MAX  = 16'd58982;
  localparam logic [15:0] FREQ_RST  = 16'd32768;
  localparam logic [15:0] AMP_MIN   = 16'd2048;
  localparam logic [15:0] AMP_RST   = 16'd4096;

  // datapath widths
  localparam int M_W   = 49;  // coord * frequency, Q.32
  localparam int DOT_W = 34;  // corner dot and blends, Q.30
  localparam int SUM_W = 56;  // octave sum, Q.42

  function automatic logic [31:0] rot16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // sin(pi/2 * u), u in Q1.30, result Q2.14; used at elaboration only
  function automatic logic [14:0] quarter_sine(logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    u2 = (u * u) >> 30;
    t  = SIN_C9;
    t  = SIN_C7 - ((u2 * t) >> 30);
    t  = SIN_C5 - ((u2 * t) >> 30);
    t  = SIN_C3 - ((u2 * t) >> 30);
    t  = SIN_C1 - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return r[14:0];
  endfunction

endpackage

// ===== hdl/fpn_cell.sv =====
// One octave of the chain: nine register stages, hands point and sum on.
module fpn_cell #(
  parameter int LEVEL = 0,
  parameter int AB    = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [fpn_pkg::M_W-1:0]   mx_i,
  input  logic signed [fpn_pkg::M_W-1:0]   mz_i,
  input  logic signed [fpn_pkg::SUM_W-1:0] sum_i,
  input  logic [31:0]                     seed_i,
  input  logic [15:0]                     amp_i,
  output logic                            valid_o,
  output logic signed [fpn_pkg::M_W-1:0]   mx_o,
  output logic signed [fpn_pkg::M_W-1:0]   mz_o,
  output logic signed [fpn_pkg::SUM_W-1:0] sum_o
);
  import fpn_pkg::*;

  localparam int NST = 9;
  localparam int QN  = 1 << (AB - 2);

  typedef logic [14:0] lut_t [QN];

  function automatic lut_t build_lut();
    lut_t t;
    for (int j = 0; j < QN; j++) begin
      t[j] = quarter_sine(64'(j) << (32 - AB));
    end
    return t;
  endfunction

  localparam lut_t LUT = build_lut();

  // gradient component from the top hash bits; the quarter-wave peak is exactly one
  function automatic logic signed [15:0] grad(logic [AB-1:0] k);
    logic [AB-2:0] idx;
    logic [14:0]   mag;
    idx = k[AB-2] ? ((AB-1)'(QN) - {1'b0, k[AB-3:0]}) : {1'b0, k[AB-3:0]};
    mag = (idx == (AB-1)'(QN)) ? 15'd16384 : LUT[idx[AB-3:0]];
    return k[AB-1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

  function automatic logic signed [DOT_W-1:0] blend(logic signed [DOT_W-1:0] a0,
                                                     logic signed [DOT_W-1:0] a1,
                                                     logic [16:0] f);
    logic signed [DOT_W:0]    d;
    logic signed [DOT_W+18:0] pr;
    d  = {a1[DOT_W-1], a1} - {a0[DOT_W-1], a0};
    pr = d * signed'({1'b0, f});
    return a0 + DOT_W'(pr >>> 16);
  endfunction

  // delay lines
  logic                    v_q  [NST];
  logic signed [M_W-1:0]   mx_q [NST];
  logic signed [M_W-1:0]   mz_q [NST];
  logic signed [SUM_W-1:0] s_q  [NST-1];
  logic [15:0]             sx_q [5];
  logic [15:0]             sz_q [5];
  logic [16:0]             fx_q [4];
  logic [16:0]             fz_q [5];

  // hash and gradient pipeline
  logic [31:0]             ax_q [2];
  logic [31:0]             bz_q [2];
  logic [31:0]             bz2_q [2];
  logic [31:0]             a1_q [2];
  logic [31:0]             a1b_q [2];
  logic [31:0]             b_q  [4];
  logic [AB-1:0]           k_q  [4];
  logic signed [15:0]      gx_q [4];
  logic signed [15:0]      gz_q [4];
  logic signed [DOT_W-1:0] dot_q [4];
  logic signed [DOT_W-1:0] r_q  [2];
  logic signed [DOT_W-1:0] p_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [31:0]             wwx_q;
  logic [31:0]             wwz_q;

  logic [63:0] px;
  logic [63:0] pz;
  logic [31:0] x0;
  logic [31:0] z0;

  assign px = {{(64-M_W){mx_i[M_W-1]}}, mx_i};
  assign pz = {{(64-M_W){mz_i[M_W-1]}}, mz_i};
  assign x0 = px[63-LEVEL:32-LEVEL];
  assign z0 = pz[63-LEVEL:32-LEVEL];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NST; j++) v_q[j] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int j = 1; j < NST; j++) v_q[j] <= v_q[j-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // pass-along taps
      mx_q[0] <= mx_i;
      mz_q[0] <= mz_i;
      s_q[0]  <= sum_i;
      for (int j = 1; j < NST; j++) begin
        mx_q[j] <= mx_q[j-1];
        mz_q[j] <= mz_q[j-1];
      end
      for (int j = 1; j < NST-1; j++) s_q[j] <= s_q[j-1];

      // stage 1: cell corners, fraction
      ax_q[0] <= x0 + seed_i;
      ax_q[1] <= x0 + 32'd1 + seed_i;
      bz_q[0] <= z0 + seed_i;
      bz_q[1] <= z0 + 32'd1 + seed_i;
      sx_q[0] <= px[31-LEVEL:16-LEVEL];
      sz_q[0] <= pz[31-LEVEL:16-LEVEL];
      for (int j = 1; j < 5; j++) begin
        sx_q[j] <= sx_q[j-1];
        sz_q[j] <= sz_q[j-1];
      end

      // stage 2: first hash multiply, fade square
      for (int c = 0; c < 2; c++) begin
        a1_q[c]  <= 32'(ax_q[c] * HASH_M1);
        bz2_q[c] <= bz_q[c];
      end
      wwx_q <= 32'(sx_q[0]) * 32'(sx_q[0]);
      wwz_q <= 32'(sz_q[0]) * 32'(sz_q[0]);

      // stage 3: second hash multiply, fade cubic
      for (int c = 0; c < 4; c++) begin
        b_q[c] <= 32'((bz2_q[c/2] ^ rot16(a1_q[c%2])) * HASH_M2);
      end
      for (int c = 0; c < 2; c++) a1b_q[c] <= a1_q[c];
      fx_q[0] <= 17'((50'(wwx_q) * (50'd196608 - 50'({sx_q[1], 1'b0}))) >> 32);
      fz_q[0] <= 17'((50'(wwz_q) * (50'd196608 - 50'({sz_q[1], 1'b0}))) >> 32);
      for (int j = 1; j < 4; j++) fx_q[j] <= fx_q[j-1];
      for (int j = 1; j < 5; j++) fz_q[j] <= fz_q[j-1];

      // stage 4: third hash multiply, keep angle index
      for (int c = 0; c < 4; c++) begin
        k_q[c] <= AB'(32'((a1b_q[c%2] ^ rot16(b_q[c])) * HASH_M3) >> (32 - AB));
      end

      // stage 5: gradient lookup
      for (int c = 0; c < 4; c++) begin
        gx_q[c] <= grad(k_q[c]);
        gz_q[c] <= grad(k_q[c] + AB'(QN));
      end

      // stage 6: corner dot products
      for (int c = 0; c < 4; c++) begin
        dot_q[c] <= DOT_W'(signed'({(c % 2 == 1) ? 2'b11 : 2'b00, sx_q[4]}))
                    * DOT_W'(gx_q[c])
                  + DOT_W'(signed'({(c / 2 == 1) ? 2'b11 : 2'b00, sz_q[4]}))
                    * DOT_W'(gz_q[c]);
      end

      // stage 7: blend along x
      r_q[0] <= blend(dot_q[0], dot_q[1], fx_q[3]);
      r_q[1] <= blend(dot_q[2], dot_q[3], fx_q[3]);

      // stage 8: blend along z
      p_q <= blend(r_q[0], r_q[1], fz_q[4]);

      // stage 9: weight and accumulate
      sum_q <= s_q[NST-2]
             + ((SUM_W'(p_q) * SUM_W'(signed'({1'b0, amp_i}))) >>> LEVEL);
    end
  end

  assign valid_o = v_q[NST-1];
  assign mx_o    = mx_q[NST-1];
  assign mz_o    = mz_q[NST-1];
  assign sum_o   = sum_q;

endmodule

// ===== hdl/fpn_scale.sv =====
// Final scale by 6/5 and saturation to Q1.15, two stages.
module fpn_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [fpn_pkg::SUM_W-1:0] sum_i,
  output logic                            valid_o,
  output logic signed [15:0]              data_o
);
  import fpn_pkg::*;

  localparam logic [SUM_W-25:0] SAT_LIM = (SUM_W-24)'(163845);

  logic [SUM_W-1:0]  mag;
  logic [SUM_W+2:0]  n6;
  logic [SUM_W-25:0] hf;
  logic [33:0]       prod;
  logic [15:0]       q;

  logic        v1_q;
  logic        neg_q;
  logic        sat_q;
  logic [17:0] h_q;
  logic        v2_q;
  logic [15:0] res_q;

  // magnitude times six, then drop 27 bits
  assign mag  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign n6   = {1'b0, mag, 2'b00} + {2'b00, mag, 1'b0};
  assign hf   = n6[SUM_W+2:27];
  // divide by five by reciprocal, exact below 2^18
  assign prod = 34'(h_q) * 34'd52429;
  assign q    = prod[33:18];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= sum_i[SUM_W-1];
      sat_q <= (hf >= SAT_LIM);
      h_q   <= hf[17:0];
      if (neg_q) begin
        res_q <= (sat_q || q > 16'd32768) ? 16'h8000 : 16'(-q);
      end else begin
        res_q <= (sat_q || q > 16'd32767) ? 16'h7fff : q;
      end
    end
  end

  assign valid_o = v2_q;
  assign data_o  = res_q;

endmodule

// ===== hdl/fractal_perlin_noise.sv =====
// Channel   Dir  Contents
// s_axis    in   tdata[31:0] x_coord, tdata[63:32] z_coord (signed Q16.16)
// m_axis    out  tdata[15:0] noise_value (signed Q1.15)
// cfg       in   cfg_idx_i 0 seed, 1 base_frequency, 2 base_amplitude
//
// One word per cycle in and out while the pipeline is not frozen; a word passes
// the frequency multiply register, then every octave cell in turn, then the scaler.
// The whole pipeline moves on one enable; it freezes only while a result
// sits in the output register and m_axis_tready is low.
// Reset clears valids and loads the register defaults.
module fractal_perlin_noise #(
  parameter int OCTAVES    = 12,
  parameter int ANGLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] x_coord, [63:32] z_coord
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] noise_value
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import fpn_pkg::*;

  logic [31:0] seed_q;
  logic [15:0] freq_q;
  logic [15:0] amp_q;
  logic        en;

  // config writes with clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      freq_q <= FREQ_RST;
      amp_q  <= AMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEED: seed_q <= cfg_data_i;
        REG_FREQ: begin
          if (cfg_data_i[15:0] < FREQ_MIN) freq_q <= FREQ_MIN;
          else if (cfg_data_i[15:0] > FREQ_MAX) freq_q <= FREQ_MAX;
          else freq_q <= cfg_data_i[15:0];
        end
        REG_AMP: amp_q <= (cfg_data_i[15:0] < AMP_MIN) ? AMP_MIN : cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // coordinate times base frequency
  logic                  v0_q;
  logic signed [M_W-1:0] mx0_q;
  logic signed [M_W-1:0] mz0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx0_q <= M_W'(signed'(s_axis_tdata[31:0])) * M_W'(signed'({1'b0, freq_q}));
      mz0_q <= M_W'(signed'(s_axis_tdata[63:32])) * M_W'(signed'({1'b0, freq_q}));
    end
  end

  // octave chain
  logic                    v_c   [OCTAVES+1];
  logic signed [M_W-1:0]   mx_c  [OCTAVES+1];
  logic signed [M_W-1:0]   mz_c  [OCTAVES+1];
  logic signed [SUM_W-1:0] sum_c [OCTAVES+1];

  assign v_c[0]   = v0_q;
  assign mx_c[0]  = mx0_q;
  assign mz_c[0]  = mz0_q;
  assign sum_c[0] = '0;

  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    fpn_cell #(
      .LEVEL (g),
      .AB    (ANGLE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_c[g]),
      .mx_i    (mx_c[g]),
      .mz_i    (mz_c[g]),
      .sum_i   (sum_c[g]),
      .seed_i  (seed_q),
      .amp_i   (amp_q),
      .valid_o (v_c[g+1]),
      .mx_o    (mx_c[g+1]),
      .mz_o    (mz_c[g+1]),
      .sum_o   (sum_c[g+1])
    );
  end

  fpn_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_c[OCTAVES]),
    .sum_i   (sum_c[OCTAVES]),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

`ifndef SYNTH
  a_freq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freq_q >= FREQ_MIN && freq_q <= FREQ_MAX)
    else $error("base frequency out of range");
  a_amp_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amp_q >= AMP_MIN)
    else $error("base amplitude below minimum");
  a_stall_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(mx0_q) && $stable(v0_q))
    else $error("front stage moved during stall");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fpn_pkg::*;

  localparam int OCT   = 12;
  localparam int ABITS = 10;
  localparam int LAT   = 9 * OCT + 3;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  fractal_perlin_noise #(.OCTAVES(OCT), .ANGLE_BITS(ABITS)) dut (.*);

  // predictor copy of the registers
  logic [31:0] cur_seed;
  logic [15:0] cur_freq;
  logic [15:0] cur_amp;

  logic [15:0] noise_q[$];
  int          n_err = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      n_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // floor division by 2^s for signed values
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sine_q14(logic [31:0] k);
    logic [31:0] kk;
    logic [1:0]  quad;
    logic [63:0] u, u2, t, s, r;
    kk   = k & ((32'd1 << ABITS) - 1);
    quad = kk[ABITS-1 -: 2];
    u    = 64'(kk & ((32'd1 << (ABITS - 2)) - 1)) << (32 - ABITS);
    if (quad[0]) u = 64'd1073741824 - u;
    u2 = (u * u) >> 30;
    t  = 64'd172272;
    t  = 64'd5026995 - ((u2 * t) >> 30);
    t  = 64'd85569306 - ((u2 * t) >> 30);
    t  = 64'd693598669 - ((u2 * t) >> 30);
    t  = 64'd1686629713 - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return quad[1] ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cz,
                                          longint dx, longint dz);
    logic [31:0] a, b, k;
    a = cx + cur_seed;
    b = cz + cur_seed;
    a = a * HASH_M1;
    b = b ^ {a[15:0], a[31:16]};
    b = b * HASH_M2;
    a = a ^ {b[15:0], b[31:16]};
    a = a * HASH_M3;
    k = a >> (32 - ABITS);
    return dx * sine_q14(k) + dz * sine_q14(k + (32'd1 << (ABITS - 2)));
  endfunction

  function automatic longint smoothstep(longint w);
    logic [63:0] uw;
    uw = 64'(w);
    return longint'((uw * uw * (64'd196608 - 2 * uw)) >> 32);
  endfunction

  function automatic longint lerp_q16(longint a0, longint a1, longint f);
    return a0 + asr((a1 - a0) * f, 16);
  endfunction

  function automatic longint octave_value(longint px, longint pz);
    logic [31:0] x0, z0;
    longint sx, sz, fx, fz, n0, n1, r0, r1;
    x0 = px[63:32];
    z0 = pz[63:32];
    sx = longint'(px[31:16]);
    sz = longint'(pz[31:16]);
    fx = smoothstep(sx);
    fz = smoothstep(sz);
    n0 = gradient_dot(x0, z0, sx, sz);
    n1 = gradient_dot(x0 + 1, z0, sx - 65536, sz);
    r0 = lerp_q16(n0, n1, fx);
    n0 = gradient_dot(x0, z0 + 1, sx, sz - 65536);
    n1 = gradient_dot(x0 + 1, z0 + 1, sx - 65536, sz - 65536);
    r1 = lerp_q16(n0, n1, fx);
    return lerp_q16(r0, r1, fz);
  endfunction

  function automatic logic [15:0] fbm_noise(logic [31:0] xc, logic [31:0] zc);
    longint x, z, f, total, q;
    logic [63:0] mag;
    x = longint'($signed(xc));
    z = longint'($signed(zc));
    total = 0;
    for (int i = 0; i < OCT; i++) begin
      f = longint'(cur_freq) << i;
      total += asr(octave_value(x * f, z * f) * longint'(cur_amp), i);
    end
    mag = (total < 0) ? 64'(-total) : 64'(total);
    q = longint'((mag * 6) / (64'd5 << 27));
    if (total < 0) return (q > 32768) ? 16'h8000 : 16'(-q);
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  // result checker with random receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected word %h", m_axis_tdata);
        end else begin
          logic [15:0] exp_v;
          exp_v = noise_q.pop_front();
          if (m_axis_tdata !== exp_v) begin
            n_err++;
            if (n_err <= 10)
              $display("noise_value mismatch: exp %h got %h", exp_v, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high after the accepting edge until the next call or drain
  task automatic send_point(logic [31:0] xc, logic [31:0] zc);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {zc, xc};
    noise_q.push_back(fbm_noise(xc, zc));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_SEED: cur_seed = val;
      REG_FREQ: cur_freq = (val[15:0] < FREQ_MIN) ? FREQ_MIN :
                           (val[15:0] > FREQ_MAX) ? FREQ_MAX : val[15:0];
      REG_AMP:  cur_amp = (val[15:0] < AMP_MIN) ? AMP_MIN : val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return {16'($urandom()), 16'($urandom_range(1) ? 16'hffff : 16'h0)};
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] pts[10] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                             32'h00010000, 32'hffff0000, 32'h0000ffff,
                             32'h00008000, 32'hffff8000, 32'h12345678};
    for (int i = 0; i < 10; i++) send_point(pts[i], pts[9 - i]);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'h7fffffff, 32'h7fffffff);
    drain();
    // clamping and extremes, big amplitude for saturation
    write_reg(REG_FREQ, 32'd0);
    write_reg(REG_AMP, 32'd0);
    write_reg(REG_SEED, 32'hffffffff);
    write_reg(2'd3, 32'h1234);
    for (int i = 0; i < 5; i++) send_point(pts[i], pts[i + 5]);
    drain();
    write_reg(REG_FREQ, 32'hffff);
    write_reg(REG_AMP, 32'hffff);
    for (int i = 0; i < 8; i++) send_point(pts[i], pts[i + 1]);
    drain();
  endtask

  task automatic test_random(int n);
    int idle[4] = '{0, 58, 0, 33};
    int stall[4] = '{0, 0, 58, 33};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_SEED, $urandom());
      write_reg(REG_FREQ, ph == 0 ? 32'd58982 : $urandom_range(0, 65535));
      write_reg(REG_AMP, ph == 1 ? 32'd2048 : $urandom_range(0, 65535));
      send_idle_pct  = idle[ph];
      recv_stall_pct = stall[ph];
      for (int i = 0; i < n / 4; i++) send_point(rand_coord(), rand_coord());
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    cur_seed = '0;
    cur_freq = FREQ_RST;
    cur_amp  = AMP_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    if (n_err == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
